FILE: rtl/mkbb_pkg.sv
// Shared constants, command and status types for the makespan branch-and-bound block.
package mkbb_pkg;

  localparam int MAX_JOBS  = 12;
  localparam int MAX_LINES = 8;

  localparam int JOB_W   = 8;
  localparam int SPAN_W  = 12;
  localparam int LCFG_W  = 4;
  localparam int FIELD_W = 4;
  localparam int IDX_W   = $clog2(MAX_JOBS);
  localparam int DEPTH_W = $clog2(MAX_JOBS + 1);
  localparam int LINE_W  = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
  localparam int LNUM_W  = $clog2(MAX_LINES + 1);

  localparam logic [SPAN_W-1:0] SPAN_INF = '1;

  typedef struct packed {
    logic store;
    logic init;
    logic skip;
    logic pick;
    logic push;
    logic take_best;
    logic pop;
    logic emit_start;
    logic emit_next;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic leaf;
    logic cur_end;
    logic cand_free;
    logic fits;
    logic better;
    logic at_root;
    logic emit_last;
  } sts_t;

endpackage

FILE: rtl/mkbb_in_if.sv
// Request channel carrying one job of the set.
interface mkbb_in_if;
  import mkbb_pkg::*;
  logic              valid;
  logic              ready;
  logic [JOB_W-1:0]  job_time;
  logic              last_job;
  modport source (output valid, job_time, last_job, input ready);
  modport sink (input valid, job_time, last_job, output ready);
endinterface

FILE: rtl/mkbb_out_if.sv
// Result channel carrying one position of the best order.
interface mkbb_out_if;
  import mkbb_pkg::*;
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] order_position;
  logic [FIELD_W-1:0] job_index;
  logic [SPAN_W-1:0]  makespan;
  logic               last_result;
  modport source (output valid, order_position, job_index, makespan, last_result,
                  input ready);
  modport sink (input valid, order_position, job_index, makespan, last_result,
                output ready);
endinterface

FILE: rtl/mkbb_cfg_if.sv
// Configuration write channel for the line count register.
interface mkbb_cfg_if;
  import mkbb_pkg::*;
  logic              valid;
  logic              ready;
  logic [LCFG_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

FILE: rtl/mkbb_datapath.sv
// Datapath: job store, line loads, search stacks and best order.
module mkbb_datapath
  import mkbb_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  output sts_t               sts,
  input  logic [JOB_W-1:0]   job_time,
  input  logic               cfg_we,
  input  logic [LCFG_W-1:0]  cfg_data,
  output logic [FIELD_W-1:0] res_position,
  output logic [FIELD_W-1:0] res_job,
  output logic [SPAN_W-1:0]  res_makespan,
  output logic               res_last
);

  logic [JOB_W-1:0]   jt_r       [MAX_JOBS];
  logic [SPAN_W-1:0]  loads_r    [MAX_LINES];
  logic [SPAN_W-1:0]  span_r     [MAX_JOBS+1];
  logic [DEPTH_W-1:0] cur_r      [MAX_JOBS+1];
  logic [IDX_W-1:0]   order_r    [MAX_JOBS];
  logic [LINE_W-1:0]  pick_r     [MAX_JOBS];
  logic [IDX_W-1:0]   best_ord_r [MAX_JOBS];
  logic [DEPTH_W-1:0] cnt_r;
  logic [LCFG_W-1:0]  lines_r;
  logic [DEPTH_W-1:0] depth_r;
  logic [MAX_JOBS-1:0] mask_r;
  logic [SPAN_W-1:0]  best_r;
  logic [LINE_W-1:0]  sel_r;
  logic [SPAN_W-1:0]  new_load_r;
  logic [DEPTH_W-1:0] emit_k_r;

  logic [LNUM_W-1:0]  lines_eff;
  logic [DEPTH_W-1:0] cur_d;
  logic [IDX_W-1:0]   cand;
  logic [LINE_W-1:0]  arg_min;
  logic [SPAN_W-1:0]  span_new;
  logic [DEPTH_W-1:0] up;
  logic [IDX_W-1:0]   up_job;
  logic [LINE_W-1:0]  up_line;
  logic [DEPTH_W-1:0] cnt_inc;

  always_comb begin
    if (lines_r == '0) begin
      lines_eff = LNUM_W'(1);
    end else if (32'(lines_r) > MAX_LINES) begin
      lines_eff = LNUM_W'(MAX_LINES);
    end else begin
      lines_eff = LNUM_W'(lines_r);
    end
  end

  assign cur_d   = cur_r[depth_r];
  assign cand    = cur_d[IDX_W-1:0];
  assign up      = depth_r - DEPTH_W'(1);
  assign up_job  = order_r[up[IDX_W-1:0]];
  assign up_line = pick_r[up[IDX_W-1:0]];
  assign cnt_inc = cnt_r + DEPTH_W'(1);

  always_comb begin
    arg_min = '0;
    for (int k = 1; k < MAX_LINES; k++) begin
      if (LNUM_W'(k) < lines_eff && loads_r[k] < loads_r[arg_min]) begin
        arg_min = LINE_W'(k);
      end
    end
  end

  assign span_new = (new_load_r > span_r[depth_r]) ? new_load_r : span_r[depth_r];

  assign sts.leaf      = (depth_r == cnt_r);
  assign sts.cur_end   = (cur_d >= cnt_r);
  assign sts.cand_free = mask_r[cand];
  assign sts.fits      = (span_new <= best_r);
  assign sts.better    = (span_r[depth_r] < best_r);
  assign sts.at_root   = (depth_r == '0);
  assign sts.emit_last = ((emit_k_r + DEPTH_W'(1)) == cnt_r);

  assign res_position = FIELD_W'(emit_k_r);
  assign res_job      = FIELD_W'(best_ord_r[emit_k_r[IDX_W-1:0]]);
  assign res_makespan = best_r;
  assign res_last     = sts.emit_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      lines_r  <= LCFG_W'(1);
      depth_r  <= '0;
      mask_r   <= '0;
      best_r   <= SPAN_INF;
      emit_k_r <= '0;
    end else begin
      if (cfg_we) begin
        lines_r <= cfg_data;
      end
      if (cmd.store && 32'(cnt_r) < MAX_JOBS) begin
        jt_r[cnt_r[IDX_W-1:0]] <= job_time;
        cnt_r <= cnt_inc;
      end
      if (cmd.init) begin
        for (int k = 0; k < MAX_LINES; k++) begin
          loads_r[k] <= '0;
        end
        for (int i = 0; i < MAX_JOBS; i++) begin
          mask_r[i]     <= (DEPTH_W'(i) < cnt_r);
          best_ord_r[i] <= '0;
        end
        span_r[0] <= '0;
        cur_r[0]  <= '0;
        depth_r   <= '0;
        best_r    <= SPAN_INF;
      end
      if (cmd.skip) begin
        cur_r[depth_r] <= cur_d + DEPTH_W'(1);
      end
      if (cmd.pick) begin
        sel_r      <= arg_min;
        new_load_r <= loads_r[arg_min] + SPAN_W'(jt_r[cand]);
      end
      if (cmd.push) begin
        loads_r[sel_r]                 <= new_load_r;
        pick_r[depth_r[IDX_W-1:0]]     <= sel_r;
        order_r[depth_r[IDX_W-1:0]]    <= cand;
        mask_r[cand]                   <= 1'b0;
        span_r[depth_r + DEPTH_W'(1)]  <= span_new;
        cur_r[depth_r + DEPTH_W'(1)]   <= '0;
        depth_r                        <= depth_r + DEPTH_W'(1);
      end
      if (cmd.take_best) begin
        for (int i = 0; i < MAX_JOBS; i++) begin
          best_ord_r[i] <= order_r[i];
        end
        best_r <= span_r[depth_r];
      end
      if (cmd.pop) begin
        loads_r[up_line] <= loads_r[up_line] - SPAN_W'(jt_r[up_job]);
        mask_r[up_job]   <= 1'b1;
        cur_r[up]        <= DEPTH_W'(up_job) + DEPTH_W'(1);
        depth_r          <= up;
      end
      if (cmd.emit_start) begin
        emit_k_r <= '0;
      end
      if (cmd.emit_next) begin
        emit_k_r <= emit_k_r + DEPTH_W'(1);
      end
      if (cmd.finish) begin
        cnt_r  <= '0;
        mask_r <= '0;
      end
    end
  end

endmodule

FILE: rtl/mkbb_ctrl.sv
// Controller: sequences loading, the depth-first search and result delivery.
module mkbb_ctrl
  import mkbb_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_last,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [2:0] {S_LOAD, S_INIT, S_SCAN, S_PLACE, S_POP, S_EMIT} state_t;

  state_t state_r, state_nxt;

  assign in_ready  = (state_r == S_LOAD);
  assign out_valid = (state_r == S_EMIT);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_LOAD: begin
        if (in_valid) begin
          cmd.store = 1'b1;
          if (in_last) begin
            state_nxt = S_INIT;
          end
        end
      end
      S_INIT: begin
        cmd.init  = 1'b1;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (sts.leaf) begin
          cmd.take_best = sts.better;
          state_nxt     = S_POP;
        end else if (sts.cur_end) begin
          if (sts.at_root) begin
            cmd.emit_start = 1'b1;
            state_nxt      = S_EMIT;
          end else begin
            state_nxt = S_POP;
          end
        end else if (!sts.cand_free) begin
          cmd.skip = 1'b1;
        end else begin
          cmd.pick  = 1'b1;
          state_nxt = S_PLACE;
        end
      end
      S_PLACE: begin
        if (sts.fits) begin
          cmd.push = 1'b1;
        end else begin
          cmd.skip = 1'b1;
        end
        state_nxt = S_SCAN;
      end
      S_POP: begin
        cmd.pop   = 1'b1;
        state_nxt = S_SCAN;
      end
      S_EMIT: begin
        if (out_ready) begin
          if (sts.emit_last) begin
            cmd.finish = 1'b1;
            state_nxt  = S_LOAD;
          end else begin
            cmd.emit_next = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: rtl/makespan_branch_and_bound.sv
// A new job is accepted every cycle until the final one.
// The search starts after a setup step; each tried candidate is picked, then placed or pruned,
// a candidate already placed is skipped, and each backtrack checks the level, then restores.
// Results then leave one per cycle while the sink takes them; the next set loads after.
// Synchronous active-low reset empties the job set and sets the line count to one.
module makespan_branch_and_bound
  import mkbb_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  mkbb_in_if.sink   in_chan,
  mkbb_out_if.source out_chan,
  mkbb_cfg_if.sink  cfg_chan
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_chan.ready = 1'b1;

  mkbb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_last   (in_chan.last_job),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  mkbb_datapath u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .job_time     (in_chan.job_time),
    .cfg_we       (cfg_chan.valid),
    .cfg_data     (cfg_chan.data),
    .res_position (out_chan.order_position),
    .res_job      (out_chan.job_index),
    .res_makespan (out_chan.makespan),
    .res_last     (out_chan.last_result)
  );

endmodule

FILE: test/tb_makespan_branch_and_bound.sv
// Self-checking testbench for the makespan branch-and-bound block, predicting each best order.
module tb_makespan_branch_and_bound
  import mkbb_pkg::*;
;

  typedef struct {
    logic [JOB_W-1:0] job_time;
    logic             last_job;
  } job_req_t;

  typedef struct {
    logic [FIELD_W-1:0] position;
    logic [FIELD_W-1:0] job_index;
    logic [SPAN_W-1:0]  makespan;
    logic               last_result;
  } order_slot_t;

  localparam int IDLE_NONE = 0;
  localparam int IDLE_SEND = 1;
  localparam int IDLE_RECV = 2;
  localparam int IDLE_BOTH = 3;
  localparam int STALL_LIMIT = 2000000;
  localparam int LONG_HOLD = 400;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  mkbb_in_if  in_ch ();
  mkbb_out_if out_ch ();
  mkbb_cfg_if cfg_ch ();

  makespan_branch_and_bound uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_ch.sink),
    .out_chan (out_ch.source),
    .cfg_chan (cfg_ch.sink)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  job_req_t    job_queue[$];
  order_slot_t best_orders[$];
  job_req_t    cur_job;
  int          idle_mode = IDLE_NONE;
  int          errors = 0;
  int          hold_ticket = 0;
  int          hold_served = 0;
  int          hold_left = 0;
  int          stall_cycles = 0;

  // Predictor state: held jobs, line count and the search bookkeeping.
  logic [JOB_W-1:0]   held_times[$];
  logic [LCFG_W-1:0]  line_cfg = LCFG_W'(1);
  logic [SPAN_W-1:0]  best_span;
  logic [FIELD_W-1:0] trial_order[MAX_JOBS];
  logic [FIELD_W-1:0] winning_order[MAX_JOBS];
  logic [MAX_JOBS-1:0] unplaced;

  function automatic void branch(int depth, int n, int lines,
                                 logic [SPAN_W-1:0] loads[MAX_LINES],
                                 logic [SPAN_W-1:0] span_so_far);
    logic [SPAN_W-1:0] next_loads[MAX_LINES];
    logic [SPAN_W-1:0] span;
    int pick;
    if (depth >= n) begin
      if (span_so_far < best_span) begin
        best_span = span_so_far;
        winning_order = trial_order;
      end
      return;
    end
    for (int c = 0; c < n; c++) begin
      if (!unplaced[c]) continue;
      next_loads = loads;
      pick = 0;
      for (int k = 1; k < lines; k++)
        if (next_loads[k] < next_loads[pick]) pick = k;
      next_loads[pick] = next_loads[pick] + SPAN_W'(held_times[c]);
      span = '0;
      for (int k = 0; k < lines; k++)
        if (next_loads[k] > span) span = next_loads[k];
      if (span > best_span) continue;
      trial_order[depth] = FIELD_W'(c);
      unplaced[c] = 1'b0;
      branch(depth + 1, n, lines, next_loads, span);
      unplaced[c] = 1'b1;
    end
  endfunction

  task automatic take_job(job_req_t j);
    logic [SPAN_W-1:0] zero_loads[MAX_LINES];
    order_slot_t slot;
    int n;
    int lines;
    if (held_times.size() < MAX_JOBS) held_times.insert(held_times.size(), j.job_time);
    if (!j.last_job) return;
    n = held_times.size();
    lines = (line_cfg == 0) ? 1 : (line_cfg > MAX_LINES) ? MAX_LINES : int'(line_cfg);
    for (int k = 0; k < MAX_LINES; k++) zero_loads[k] = '0;
    for (int k = 0; k < MAX_JOBS; k++) begin
      trial_order[k] = '0;
      winning_order[k] = '0;
    end
    unplaced = MAX_JOBS'((1 << n) - 1);
    best_span = SPAN_INF;
    branch(0, n, lines, zero_loads, '0);
    for (int k = 0; k < n; k++) begin
      slot.position = FIELD_W'(k);
      slot.job_index = winning_order[k];
      slot.makespan = best_span;
      slot.last_result = (k == n - 1);
      best_orders.insert(best_orders.size(), slot);
    end
    held_times.delete();
  endtask

  function automatic bit roll_idle(int mine);
    if (idle_mode == mine) return $urandom_range(0, 99) < 83;
    if (idle_mode == IDLE_BOTH) return $urandom_range(0, 99) < 12;
    return 1'b0;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.job_time <= '0;
      in_ch.last_job <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) take_job(cur_job);
      if (!in_ch.valid || in_ch.ready) begin
        if (job_queue.size() > 0 && !roll_idle(IDLE_SEND)) begin
          cur_job = job_queue.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.job_time <= cur_job.job_time;
          in_ch.last_job <= cur_job.last_job;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    order_slot_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (best_orders.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result: pos %0d job %0d span %0d",
                                     out_ch.order_position, out_ch.job_index, out_ch.makespan);
        end else begin
          want = best_orders.pop_front();
          if (out_ch.order_position !== want.position || out_ch.job_index !== want.job_index ||
              out_ch.makespan !== want.makespan || out_ch.last_result !== want.last_result) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: expected pos %0d job %0d span %0d last %0b, got %0d %0d %0d %0b",
                       want.position, want.job_index, want.makespan, want.last_result,
                       out_ch.order_position, out_ch.job_index, out_ch.makespan,
                       out_ch.last_result);
          end
        end
      end
      if (hold_served != hold_ticket && out_ch.valid) begin
        hold_served <= hold_ticket;
        hold_left <= LONG_HOLD;
        out_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= !roll_idle(IDLE_RECV);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("tb_makespan_branch_and_bound: done, errors");
      $finish;
    end
  end

  task automatic add_set(int n, int lo, int hi);
    job_req_t j;
    for (int k = 0; k < n; k++) begin
      j.job_time = JOB_W'($urandom_range(lo, hi));
      j.last_job = (k == n - 1);
      job_queue.insert(job_queue.size(), j);
    end
  endtask

  task automatic add_job(int t, bit last);
    job_req_t j;
    j.job_time = JOB_W'(t);
    j.last_job = last;
    job_queue.insert(job_queue.size(), j);
  endtask

  task automatic settle();
    wait (job_queue.size() == 0 && !in_ch.valid && best_orders.size() == 0);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_lines(int v);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= LCFG_W'(v);
    do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
    line_cfg = LCFG_W'(v);
    cfg_ch.valid <= 1'b0;
  endtask

  // Full sets of twelve jobs are too slow to search exhaustively, so sets stay small.
  task automatic random_phase(int items, int mode);
    int n;
    int r;
    idle_mode = mode;
    while (items > 0) begin
      r = $urandom_range(0, 39);
      n = (r == 0) ? 7 : (r < 3) ? 6 : $urandom_range(1, 5);
      if ($urandom_range(0, 3) == 0) add_set(n, 1, 6);
      else add_set(n, 0, 255);
      items -= n;
    end
    settle();
  endtask

  initial begin
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    add_job(255, 1);
    add_job(1, 0); add_job(255, 1);
    add_job(0, 0); add_job(0, 0); add_job(7, 1);
    settle();
    write_lines(8);
    add_job(255, 0); add_job(128, 0); add_job(1, 0); add_job(64, 1);
    add_job(10, 0); add_job(10, 0); add_job(10, 0); add_job(10, 1);
    settle();
    write_lines(0);
    add_job(3, 0); add_job(5, 0); add_job(2, 1);
    settle();
    write_lines(15);
    add_job(9, 0); add_job(200, 0); add_job(170, 0); add_job(85, 1);
    settle();

    write_lines(2);
    random_phase(55, IDLE_NONE);
    write_lines(1);
    random_phase(50, IDLE_SEND);
    write_lines(3);
    random_phase(55, IDLE_RECV);
    write_lines(8);
    random_phase(55, IDLE_BOTH);
    write_lines(4);
    hold_ticket++;
    random_phase(55, IDLE_NONE);
    write_lines(15);
    random_phase(40, IDLE_BOTH);

    repeat (100) @(posedge clk);
    if (errors == 0 && best_orders.size() == 0)
      $display("tb_makespan_branch_and_bound: done, clean");
    else
      $display("tb_makespan_branch_and_bound: done, errors");
    $finish;
  end
endmodule

FILE: files.f
rtl/mkbb_pkg.sv
rtl/mkbb_in_if.sv
rtl/mkbb_out_if.sv
rtl/mkbb_cfg_if.sv
rtl/mkbb_datapath.sv
rtl/mkbb_ctrl.sv
rtl/makespan_branch_and_bound.sv
test/tb_makespan_branch_and_bound.sv
